### src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (c)) \
    else $error("assertion failed");

// consequence in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");

// consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");

`endif

### src/ffha_pkg.sv
`default_nettype none

package ffha_pkg;

  localparam int FIELD_W  = 12;
  localparam int STATUS_W = 2;

  localparam logic [FIELD_W-1:0] HEAP_SIZE_RESET = 12'd1000;

  localparam logic OP_FREE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_ALLOC_OK  = 2'd0,
    STAT_BAD_SIZE  = 2'd1,
    STAT_NO_FIT    = 2'd2,
    STAT_FREE_DONE = 2'd3
  } status_t;

  typedef struct packed {
    logic    init;
    logic    load_in;
    logic    walk_start;
    logic    walk_addr;
    logic    walk_adv;
    logic    unlink;
    logic    split_tail;
    logic    split_head;
    logic    free_calc;
    logic    free_commit;
    logic    res_load;
    status_t res_status;
  } ffha_cmd_t;

  typedef struct packed {
    logic op_free;
    logic req_zero;
    logic null_free;
    logic cur_ok;
    logic steps_over;
    logic fits;
    logic can_split;
  } ffha_stat_t;

endpackage

`default_nettype wire

### src/ffha_ctrl.sv
`default_nettype none

module ffha_ctrl import ffha_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output ffha_cmd_t  cmd,
  input  ffha_stat_t stat
);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_PREP,
    S_ADDR,
    S_CHECK,
    S_SPLIT_TAIL,
    S_SPLIT_HEAD,
    S_FREE_COMMIT,
    S_DONE
  } state_t;

  state_t  state_r, state_nxt;
  status_t res_r, res_nxt;
  logic    out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE) && !cfg_we;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt      = state_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    cmd            = '0;
    cmd.res_status = res_r;
    unique case (state_r)
      S_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (cfg_we) begin
          state_nxt = S_INIT;
        end else if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_PREP;
        end
      end
      S_PREP: begin
        if (stat.op_free) begin
          if (stat.null_free) begin
            res_nxt   = STAT_FREE_DONE;
            state_nxt = S_DONE;
          end else begin
            cmd.free_calc = 1'b1;
            state_nxt     = S_FREE_COMMIT;
          end
        end else if (stat.req_zero) begin
          res_nxt   = STAT_BAD_SIZE;
          state_nxt = S_DONE;
        end else begin
          cmd.walk_start = 1'b1;
          state_nxt      = S_ADDR;
        end
      end
      S_ADDR: begin
        if (!stat.cur_ok || stat.steps_over) begin
          res_nxt   = STAT_NO_FIT;
          state_nxt = S_DONE;
        end else begin
          cmd.walk_addr = 1'b1;
          state_nxt     = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.fits) begin
          if (stat.can_split) begin
            state_nxt = S_SPLIT_TAIL;
          end else begin
            cmd.unlink = 1'b1;
            res_nxt    = STAT_ALLOC_OK;
            state_nxt  = S_DONE;
          end
        end else begin
          cmd.walk_adv = 1'b1;
          state_nxt    = S_ADDR;
        end
      end
      S_SPLIT_TAIL: begin
        cmd.split_tail = 1'b1;
        state_nxt      = S_SPLIT_HEAD;
      end
      S_SPLIT_HEAD: begin
        cmd.split_head = 1'b1;
        res_nxt        = STAT_ALLOC_OK;
        state_nxt      = S_DONE;
      end
      S_FREE_COMMIT: begin
        cmd.free_commit = 1'b1;
        res_nxt         = STAT_FREE_DONE;
        state_nxt       = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.res_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      res_r       <= STAT_ALLOC_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_r       <= res_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

### src/ffha_dp.sv
`default_nettype none

module ffha_dp import ffha_pkg::*; #(
  parameter int HEAP_BYTES     = 4096,
  parameter int OVERHEAD_BYTES = 16,
  parameter int ALIGN_BYTES    = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [FIELD_W-1:0]  cfg_wdata,
  input  logic                in_op,
  input  logic [FIELD_W-1:0]  in_req_bytes,
  input  logic [FIELD_W-1:0]  in_data_offset,
  input  ffha_cmd_t           cmd,
  output ffha_stat_t          stat,
  output logic [FIELD_W-1:0]  out_alloc_offset,
  output logic [STATUS_W-1:0] out_status
);

  localparam int OFF_W      = $clog2(HEAP_BYTES);
  localparam int SLOT_COUNT = (HEAP_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int STEP_W     = $clog2(SLOT_COUNT + 2);
  localparam int ALIGN_L    = $clog2(ALIGN_BYTES);
  // request plus alignment slack, also wide enough for aligned size plus header
  localparam int REQ_W      = FIELD_W + 1;
  localparam int NEED_W     = FIELD_W + 1;
  localparam int SUM_W      = ((OFF_W > NEED_W) ? OFF_W : NEED_W) + 1;

  // exact division by the alignment through a rounded-up reciprocal
  localparam int     SH_OFF  = OFF_W + ALIGN_L;
  localparam longint RCP_OFF = ((longint'(1) << SH_OFF) + ALIGN_BYTES - 1) / ALIGN_BYTES;
  localparam int     POFF_W  = 2 * OFF_W + 1;
  localparam int     SH_REQ  = REQ_W + ALIGN_L;
  localparam longint RCP_REQ = ((longint'(1) << SH_REQ) + ALIGN_BYTES - 1) / ALIGN_BYTES;
  localparam int     PREQ_W  = 2 * REQ_W + 1;

  // wrap by restoring subtraction, quotient bound from a FIELD_W-wide operand
  localparam int QMAX = (HEAP_BYTES + (1 << FIELD_W) - 1) / HEAP_BYTES;
  localparam int QB   = $clog2(QMAX + 1);

  localparam logic [SUM_W-1:0]  HEAP_S    = SUM_W'(HEAP_BYTES);
  localparam logic [OFF_W:0]    HEAP_E    = (OFF_W + 1)'(HEAP_BYTES);
  localparam logic [OFF_W:0]    OVH_E     = (OFF_W + 1)'(OVERHEAD_BYTES);
  localparam logic [OFF_W-1:0]  OVH_O     = OFF_W'(OVERHEAD_BYTES);
  localparam logic [OFF_W-1:0]  WRAP_O    = OFF_W'(HEAP_BYTES - OVERHEAD_BYTES);
  localparam logic [NEED_W-1:0] OVH_N     = NEED_W'(OVERHEAD_BYTES);
  localparam logic [NEED_W:0]   SPLIT_MIN = (NEED_W + 1)'(OVERHEAD_BYTES + ALIGN_BYTES);

  typedef struct packed {
    logic             ok;
    logic [OFF_W-1:0] off;
  } link_t;

  function automatic logic [OFF_W-1:0] heap_mod(input logic [SUM_W-1:0] v);
    logic [SUM_W-1:0] r;
    r = v;
    for (int i = QB - 1; i >= 0; i--) begin
      if (r >= (HEAP_S << i)) r = r - (HEAP_S << i);
    end
    return r[OFF_W-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] slot_of(input logic [OFF_W-1:0] off);
    logic [POFF_W-1:0] p;
    p = POFF_W'(off) * POFF_W'(RCP_OFF);
    return SLOT_W'(p >> SH_OFF);
  endfunction

  function automatic logic [REQ_W-1:0] round_q(input logic [FIELD_W-1:0] req);
    logic [REQ_W-1:0]  t;
    logic [PREQ_W-1:0] p;
    t = {1'b0, req} + REQ_W'(ALIGN_BYTES - 1);
    p = PREQ_W'(t) * PREQ_W'(RCP_REQ);
    return REQ_W'(p >> SH_REQ);
  endfunction

  // header store, split into size and link halves
  logic [FIELD_W-1:0] size_mem [SLOT_COUNT];
  link_t              link_mem [SLOT_COUNT];

  logic [FIELD_W-1:0]  heap_size_r;
  logic [OFF_W-1:0]    head_r;
  logic                head_ok_r;
  logic                op_r;
  logic                req_zero_r;
  logic [REQ_W-1:0]    q_r;
  logic [FIELD_W-1:0]  doff_r;
  logic [REQ_W-1:0]    aligned_r;
  logic [NEED_W-1:0]   need_r;
  logic [OFF_W-1:0]    cur_r;
  logic                cur_ok_r;
  logic [SLOT_W-1:0]   cur_slot_r;
  logic [SLOT_W-1:0]   prev_slot_r;
  logic                prev_ok_r;
  logic [STEP_W-1:0]   steps_r;
  logic [OFF_W-1:0]    nb_r;
  logic [OFF_W-1:0]    blk_r;
  logic [FIELD_W-1:0]  size_rd_r;
  link_t               link_rd_r;
  logic [FIELD_W-1:0]  out_alloc_offset_r;
  logic [STATUS_W-1:0] out_status_r;

  logic [SLOT_W-1:0]  cur_slot;
  logic [REQ_W-1:0]   aligned_nxt;
  logic [OFF_W-1:0]   doff_mod;
  logic [OFF_W-1:0]   blk_nxt;
  logic [OFF_W:0]     res_sum;
  logic [OFF_W-1:0]   res_off;
  logic               sz_we;
  logic [SLOT_W-1:0]  sz_addr;
  logic [FIELD_W-1:0] sz_wdata;
  logic               lk_we;
  logic [SLOT_W-1:0]  lk_addr;
  link_t              lk_wdata;
  logic               sl_en;
  link_t              sl_data;
  logic               head_we;
  link_t              head_wdata;
  logic [NEED_W-1:0]  rest_size;

  assign cur_slot    = slot_of(cur_r);
  assign aligned_nxt = REQ_W'(q_r * ALIGN_BYTES);
  assign doff_mod    = heap_mod(SUM_W'(doff_r));
  assign blk_nxt     = (doff_mod >= OVH_O) ? (doff_mod - OVH_O) : (doff_mod + WRAP_O);
  assign res_sum     = {1'b0, cur_r} + OVH_E;
  assign res_off     = (res_sum >= HEAP_E) ? OFF_W'(res_sum - HEAP_E) : res_sum[OFF_W-1:0];
  assign rest_size   = NEED_W'(size_rd_r) - need_r;

  always_comb begin
    stat.op_free    = (op_r == OP_FREE);
    stat.req_zero   = req_zero_r;
    stat.null_free  = (doff_r == '0);
    stat.cur_ok     = cur_ok_r;
    stat.steps_over = (steps_r > STEP_W'(SLOT_COUNT));
    stat.fits       = (NEED_W'(size_rd_r) >= need_r);
    stat.can_split  = ((NEED_W + 1)'(size_rd_r) >= ((NEED_W + 1)'(need_r) + SPLIT_MIN));
  end

  // write selection for both memories and the list head
  always_comb begin
    sz_we      = 1'b0;
    sz_addr    = '0;
    sz_wdata   = '0;
    lk_we      = 1'b0;
    lk_addr    = '0;
    lk_wdata   = '0;
    sl_en      = 1'b0;
    sl_data    = '0;
    head_we    = 1'b0;
    head_wdata = '0;
    if (cmd.init) begin
      sz_we    = 1'b1;
      sz_wdata = heap_size_r;
      lk_we    = 1'b1;
    end
    if (cmd.free_commit) begin
      lk_we      = 1'b1;
      lk_addr    = slot_of(blk_r);
      lk_wdata   = '{ok: head_ok_r, off: head_r};
      head_we    = 1'b1;
      head_wdata = '{ok: 1'b1, off: blk_r};
    end
    if (cmd.unlink) begin
      sl_en   = 1'b1;
      sl_data = link_rd_r;
    end
    if (cmd.split_tail) begin
      sz_we    = 1'b1;
      sz_addr  = slot_of(nb_r);
      sz_wdata = rest_size[FIELD_W-1:0];
      lk_we    = 1'b1;
      lk_addr  = slot_of(nb_r);
      lk_wdata = link_rd_r;
    end
    if (cmd.split_head) begin
      sz_we    = 1'b1;
      sz_addr  = cur_slot_r;
      sz_wdata = aligned_r[FIELD_W-1:0];
      sl_en    = 1'b1;
      sl_data  = '{ok: 1'b1, off: nb_r};
    end
    // relink the predecessor, or the head when the hit is the first block
    if (sl_en) begin
      if (prev_ok_r) begin
        lk_we    = 1'b1;
        lk_addr  = prev_slot_r;
        lk_wdata = sl_data;
      end else begin
        head_we    = 1'b1;
        head_wdata = sl_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sz_we) begin
      size_mem[sz_addr] <= sz_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (lk_we) begin
      link_mem[lk_addr] <= lk_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_addr) begin
      size_rd_r <= size_mem[cur_slot];
      link_rd_r <= link_mem[cur_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_size_r <= HEAP_SIZE_RESET;
      head_r      <= '0;
      head_ok_r   <= 1'b1;
      prev_ok_r   <= 1'b0;
      steps_r     <= '0;
      cur_ok_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        heap_size_r <= cfg_wdata;
      end
      if (cmd.init) begin
        head_r    <= '0;
        head_ok_r <= 1'b1;
      end else if (head_we) begin
        head_r    <= head_wdata.off;
        head_ok_r <= head_wdata.ok;
      end
      if (cmd.walk_start) begin
        cur_r     <= head_r;
        cur_ok_r  <= head_ok_r;
        prev_ok_r <= 1'b0;
        steps_r   <= '0;
      end
      if (cmd.walk_adv) begin
        prev_slot_r <= cur_slot_r;
        prev_ok_r   <= 1'b1;
        cur_r       <= link_rd_r.off;
        cur_ok_r    <= link_rd_r.ok;
        steps_r     <= steps_r + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r       <= in_op;
      req_zero_r <= (in_req_bytes == '0);
      q_r        <= round_q(in_req_bytes);
      doff_r     <= in_data_offset;
    end
    if (cmd.walk_start) begin
      aligned_r <= aligned_nxt;
      need_r    <= NEED_W'(aligned_nxt) + OVH_N;
    end
    if (cmd.walk_addr) begin
      cur_slot_r <= cur_slot;
      nb_r       <= heap_mod(SUM_W'(cur_r) + SUM_W'(need_r));
    end
    if (cmd.free_calc) begin
      blk_r <= blk_nxt;
    end
    if (cmd.res_load) begin
      out_status_r       <= cmd.res_status;
      out_alloc_offset_r <= (cmd.res_status == STAT_ALLOC_OK) ? FIELD_W'(res_off) : '0;
    end
  end

  assign out_alloc_offset = out_alloc_offset_r;
  assign out_status       = out_status_r;

endmodule

`default_nettype wire

### src/first_fit_heap_allocator.sv
// from accept to result: free runs S_PREP, S_FREE_COMMIT, S_DONE; null free or zero
// size S_PREP, S_DONE; allocate adds S_ADDR, S_CHECK per block up to a hit, plus
// S_SPLIT_TAIL, S_SPLIT_HEAD when split; no fit exits S_ADDR; new requests wait for
// the result load; the walk reads a header per S_ADDR from the single-port header store
// reset, and a heap_size write in idle, run S_INIT, which writes the slot 0 header
`default_nettype none
`include "assert_macros.svh"

module first_fit_heap_allocator import ffha_pkg::*; #(
  parameter int HEAP_BYTES     = 4096,
  parameter int OVERHEAD_BYTES = 16,
  parameter int ALIGN_BYTES    = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [FIELD_W-1:0]  cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_op,
  input  logic [FIELD_W-1:0]  in_req_bytes,
  input  logic [FIELD_W-1:0]  in_data_offset,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [FIELD_W-1:0]  out_alloc_offset,
  output logic [STATUS_W-1:0] out_status
);

  ffha_cmd_t  cmd;
  ffha_stat_t stat;

  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  ffha_dp #(
    .HEAP_BYTES     (HEAP_BYTES),
    .OVERHEAD_BYTES (OVERHEAD_BYTES),
    .ALIGN_BYTES    (ALIGN_BYTES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_op            (in_op),
    .in_req_bytes     (in_req_bytes),
    .in_data_offset   (in_data_offset),
    .cmd              (cmd),
    .stat             (stat),
    .out_alloc_offset (out_alloc_offset),
    .out_status       (out_status)
  );

  `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)
  `ASSERT_NEXT(a_load_shows_result, clk, rst_n, cmd.res_load, out_valid)
  `ASSERT_IMPLIES(a_offset_zero_on_fail, clk, rst_n, out_valid && (out_status != STAT_ALLOC_OK), out_alloc_offset == '0)
  `ASSERT_ALWAYS(a_mem_cmd_excl, clk, rst_n, $onehot0({cmd.init, cmd.walk_addr, cmd.unlink, cmd.split_tail, cmd.split_head, cmd.free_commit}))

endmodule

`default_nettype wire
